// ===== rtl/gpl_pkg.sv =====
// Shared types, key-set tables and reciprocal tables for the gradient palette lookup.
// Used by every gpl_* stage module and by the top level gradient_palette_lookup.
package gpl_pkg;

    localparam int NUM_PRESETS = 7;
    localparam int MAX_KEYS    = 9;
    localparam int NUM_SEGS    = MAX_KEYS - 1;
    localparam int NUM_CHAN    = 3;

    // Quotients are formed as (dividend * recip) >> RECIP_SHIFT.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_ONE   = 2 ** RECIP_SHIFT;

    typedef logic [6:0]  pos_t;
    typedef logic [2:0]  sel_t;
    typedef logic [2:0]  seg_t;
    typedef logic [3:0]  key_t;
    typedef logic [23:0] color_t;
    typedef logic [23:0] recip_t;
    typedef logic [15:0] dividend_t;

    localparam pos_t LAST_POS = 7'd99;
    localparam sel_t MAX_PRESET = 3'd6;

    localparam key_t KEY_COUNT [0:NUM_PRESETS-1] = '{
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd7, 4'd9
    };

    localparam pos_t KEY_POS [0:NUM_PRESETS-1][0:MAX_KEYS-1] = '{
        '{7'd0, 7'd99, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
        '{7'd0, 7'd99, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
        '{7'd0, 7'd99, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
        '{7'd0, 7'd99, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
        '{7'd0, 7'd99, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
        '{7'd0, 7'd15, 7'd30, 7'd45, 7'd60, 7'd75, 7'd99, 7'd0,  7'd0},
        '{7'd0, 7'd10, 7'd59, 7'd61, 7'd63, 7'd70, 7'd78, 7'd80, 7'd99}
    };

    localparam color_t KEY_COL [0:NUM_PRESETS-1][0:MAX_KEYS-1] = '{
        '{24'h0000ff, 24'hff0000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{24'hff00ff, 24'h0070ff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{24'hff0000, 24'hffff00, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{24'h00ff00, 24'hff00ff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{24'h333333, 24'hffffff, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
        '{24'hff0000, 24'hffa500, 24'hffff00, 24'h00f000, 24'h0060ff, 24'h8b00f2,
          24'hee82ee, 24'h0, 24'h0},
        '{24'h000001, 24'h004c75, 24'h0094e3, 24'he0cda9, 24'h72cc00, 24'h298000,
          24'h4f3000, 24'hffffff, 24'hffffff}
    };

    // Reciprocals of 2*d, rounded up, for each gap length d between keys.
    localparam recip_t RECIP_D1  = recip_t'((RECIP_ONE + 2 * 1 - 1) / (2 * 1));
    localparam recip_t RECIP_D6  = recip_t'((RECIP_ONE + 2 * 6 - 1) / (2 * 6));
    localparam recip_t RECIP_D7  = recip_t'((RECIP_ONE + 2 * 7 - 1) / (2 * 7));
    localparam recip_t RECIP_D9  = recip_t'((RECIP_ONE + 2 * 9 - 1) / (2 * 9));
    localparam recip_t RECIP_D14 = recip_t'((RECIP_ONE + 2 * 14 - 1) / (2 * 14));
    localparam recip_t RECIP_D18 = recip_t'((RECIP_ONE + 2 * 18 - 1) / (2 * 18));
    localparam recip_t RECIP_D23 = recip_t'((RECIP_ONE + 2 * 23 - 1) / (2 * 23));
    localparam recip_t RECIP_D48 = recip_t'((RECIP_ONE + 2 * 48 - 1) / (2 * 48));
    localparam recip_t RECIP_D98 = recip_t'((RECIP_ONE + 2 * 98 - 1) / (2 * 98));
    localparam recip_t RECIP_NONE = '0;

    localparam recip_t SEG_RECIP [0:NUM_PRESETS-1][0:NUM_SEGS-1] = '{
        '{RECIP_D98, RECIP_NONE, RECIP_NONE, RECIP_NONE,
          RECIP_NONE, RECIP_NONE, RECIP_NONE, RECIP_NONE},
        '{RECIP_D98, RECIP_NONE, RECIP_NONE, RECIP_NONE,
          RECIP_NONE, RECIP_NONE, RECIP_NONE, RECIP_NONE},
        '{RECIP_D98, RECIP_NONE, RECIP_NONE, RECIP_NONE,
          RECIP_NONE, RECIP_NONE, RECIP_NONE, RECIP_NONE},
        '{RECIP_D98, RECIP_NONE, RECIP_NONE, RECIP_NONE,
          RECIP_NONE, RECIP_NONE, RECIP_NONE, RECIP_NONE},
        '{RECIP_D98, RECIP_NONE, RECIP_NONE, RECIP_NONE,
          RECIP_NONE, RECIP_NONE, RECIP_NONE, RECIP_NONE},
        '{RECIP_D14, RECIP_D14, RECIP_D14, RECIP_D14,
          RECIP_D14, RECIP_D23, RECIP_NONE, RECIP_NONE},
        '{RECIP_D9, RECIP_D48, RECIP_D1, RECIP_D1,
          RECIP_D6, RECIP_D7, RECIP_D1, RECIP_D18}
    };

    // Valid bit offered to a stage and its load enable.
    typedef struct packed {
        logic valid;
        logic load;
    } gpl_ctl_t;

    typedef struct packed {
        pos_t pos;
        sel_t sel;
        seg_t seg;
        logic found;
    } gpl_loc_t;

    typedef struct packed {
        color_t c_lo;
        color_t c_hi;
        pos_t   t;
        pos_t   d;
        recip_t recip;
        logic   direct;
    } gpl_fetch_t;

    typedef struct packed {
        logic [NUM_CHAN-1:0][15:0] dividend;
        recip_t recip;
        color_t color;
        logic   direct;
    } gpl_blend_t;

endpackage

// ===== rtl/gradient_palette_lookup.sv =====
// Top level of the gradient palette lookup: preset register, stage control, assertions.
// Depends on gpl_pkg and the stage modules gpl_locate, gpl_fetch, gpl_blend, gpl_scale.
//
// Usage:
// The input channel (in_valid, in_stall, position) carries one palette position per
// transfer; the output channel (out_valid, out_stall, palette_color) returns its 24-bit
// color, red in the top byte. Results leave in the order the positions came in.
// preset_select is written whenever preset_select_we is high; write it only while no
// lookup is in flight. Values above six select key set zero.
// The pipeline has four register stages: segment search, table read, channel weighting,
// and the reciprocal multiply that also serves as the output register. While
// out_stall is low, one transfer per cycle is sustained in both directions; the
// three multiply banks set the cycle time. While out_stall is high, stages behind
// the output keep filling any empty slot, so in_stall rises only when all four stages
// hold an item. Reset clears every stage's valid bit and sets preset_select to zero.
module gradient_palette_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        preset_select_we,
    input  logic [3:0]  preset_select,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [6:0]  position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] palette_color
);
    import gpl_pkg::*;

    logic [3:0] preset_select_reg;
    logic       v1;
    logic       v2;
    logic       v3;
    logic       v4;
    logic       rdy1;
    logic       rdy2;
    logic       rdy3;
    logic       rdy4;
    gpl_ctl_t   ctl1;
    gpl_ctl_t   ctl2;
    gpl_ctl_t   ctl3;
    gpl_ctl_t   ctl4;
    gpl_loc_t   loc_data;
    gpl_fetch_t fetch_data;
    gpl_blend_t blend_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_select_reg <= '0;
        end
        else if (preset_select_we)
        begin
            preset_select_reg <= preset_select;
        end
    end

    // A stage may load when it is empty or its item moves on this cycle.
    assign rdy4 = !v4 || !out_stall;
    assign rdy3 = !v3 || rdy4;
    assign rdy2 = !v2 || rdy3;
    assign rdy1 = !v1 || rdy2;

    assign ctl1 = '{valid: in_valid, load: rdy1};
    assign ctl2 = '{valid: v1, load: rdy2};
    assign ctl3 = '{valid: v2, load: rdy3};
    assign ctl4 = '{valid: v3, load: rdy4};

    assign in_stall  = !rdy1;
    assign out_valid = v4;

    gpl_locate u_locate (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl1),
        .position   (position),
        .preset_sel (preset_select_reg),
        .valid      (v1),
        .data       (loc_data)
    );

    gpl_fetch u_fetch (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl2),
        .loc   (loc_data),
        .valid (v2),
        .data  (fetch_data)
    );

    gpl_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl3),
        .fetch (fetch_data),
        .valid (v3),
        .data  (blend_data)
    );

    gpl_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl4),
        .blend (blend_data),
        .valid (v4),
        .color (palette_color)
    );

    // Back pressure reaches the input only when every stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1 && v2 && v3 && v4))
        else $error("input stalled while the pipeline has an empty stage");

    // An interpolated segment has a nonzero gap and a reciprocal of 2*d, rounded up.
    a_recip_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (v2 && !fetch_data.direct) |->
        (fetch_data.d != 7'd0) &&
        (32'(fetch_data.recip) * 32'({fetch_data.d, 1'b0}) >= 32'(RECIP_ONE)) &&
        (32'(fetch_data.recip) * 32'({fetch_data.d, 1'b0}) <
         32'(RECIP_ONE) + 32'({fetch_data.d, 1'b0})))
        else $error("reciprocal does not match the segment gap");

    // A blocked weighting stage keeps its item until the output stage frees up.
    a_blend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3 && !rdy3) |=> (v3 && $stable(blend_data)))
        else $error("weighting stage changed while blocked");

endmodule

// ===== rtl/gpl_locate.sv =====
// First pipeline stage: clamps the position, maps the preset and finds the key segment.
// Depends on gpl_pkg for the key tables and stage structs.
module gpl_locate (
    input  logic              clk,
    input  logic              rst_n,
    input  gpl_pkg::gpl_ctl_t ctl,
    input  logic [6:0]        position,
    input  logic [3:0]        preset_sel,
    output logic              valid,
    output gpl_pkg::gpl_loc_t data
);
    import gpl_pkg::*;

    logic                valid_reg;
    gpl_loc_t            data_reg;
    gpl_loc_t            data_next;
    logic [NUM_SEGS-1:0] hit;

    always_comb
    begin
        data_next = '0;
        data_next.pos = (position > LAST_POS) ? LAST_POS : position;
        data_next.sel = (preset_sel > 4'(MAX_PRESET)) ? sel_t'(0) : preset_sel[2:0];
        // A segment starting at key i covers positions below key i+1.
        for (int i = 0; i < NUM_SEGS; i++)
        begin
            hit[i] = (key_t'(i + 1) < KEY_COUNT[data_next.sel]) &&
                     (KEY_POS[data_next.sel][i + 1] > data_next.pos);
        end
        data_next.found = |hit;
        for (int i = NUM_SEGS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                data_next.seg = seg_t'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== rtl/gpl_fetch.sv =====
// Second pipeline stage: reads key colors, gap length and reciprocal from the tables.
// Depends on gpl_pkg for the key tables and stage structs.
module gpl_fetch (
    input  logic                clk,
    input  logic                rst_n,
    input  gpl_pkg::gpl_ctl_t   ctl,
    input  gpl_pkg::gpl_loc_t   loc,
    output logic                valid,
    output gpl_pkg::gpl_fetch_t data
);
    import gpl_pkg::*;

    logic       valid_reg;
    gpl_fetch_t data_reg;
    gpl_fetch_t data_next;
    pos_t       kp_lo;
    pos_t       kp_hi;
    key_t       seg_hi;
    key_t       last_key;

    always_comb
    begin
        seg_hi   = key_t'(loc.seg) + 4'd1;
        last_key = KEY_COUNT[loc.sel] - 4'd1;
        kp_lo    = KEY_POS[loc.sel][loc.seg];
        kp_hi    = KEY_POS[loc.sel][seg_hi];
        data_next       = '0;
        data_next.d     = kp_hi - kp_lo - 7'd1;
        data_next.t     = loc.pos - kp_lo;
        data_next.recip = SEG_RECIP[loc.sel][loc.seg];
        if (!loc.found)
        begin
            // Only the last key position reaches here.
            data_next.c_lo   = KEY_COL[loc.sel][last_key];
            data_next.direct = 1'b1;
        end
        else
        begin
            data_next.c_lo   = KEY_COL[loc.sel][loc.seg];
            data_next.c_hi   = KEY_COL[loc.sel][seg_hi];
            data_next.direct = (data_next.d == 7'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== rtl/gpl_blend.sv =====
// Third pipeline stage: weights the two key colors per channel into a rounding dividend.
// Depends on gpl_pkg for the stage structs.
module gpl_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  gpl_pkg::gpl_ctl_t   ctl,
    input  gpl_pkg::gpl_fetch_t fetch,
    output logic                valid,
    output gpl_pkg::gpl_blend_t data
);
    import gpl_pkg::*;

    logic                      valid_reg;
    gpl_blend_t                data_reg;
    gpl_blend_t                data_next;
    pos_t                      w_lo;
    logic [NUM_CHAN-1:0][14:0] prod_lo;
    logic [NUM_CHAN-1:0][14:0] prod_hi;
    logic [NUM_CHAN-1:0][14:0] num;

    always_comb
    begin
        w_lo = fetch.d - fetch.t;
        data_next        = '0;
        data_next.recip  = fetch.recip;
        data_next.color  = fetch.c_lo;
        data_next.direct = fetch.direct;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            prod_lo[ch] = 15'(fetch.c_lo[ch * 8 +: 8]) * 15'(w_lo);
            prod_hi[ch] = 15'(fetch.c_hi[ch * 8 +: 8]) * 15'(fetch.t);
            num[ch]     = prod_lo[ch] + prod_hi[ch];
            // Adding d to twice the numerator makes the later floor round half up.
            data_next.dividend[ch] = {num[ch], 1'b0} + 16'(fetch.d);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== rtl/gpl_scale.sv =====
// Last pipeline stage and output register: divides by 2*d through a reciprocal product.
// Depends on gpl_pkg for the stage structs and the reciprocal scale.
module gpl_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  gpl_pkg::gpl_ctl_t   ctl,
    input  gpl_pkg::gpl_blend_t blend,
    output logic                valid,
    output logic [23:0]         color
);
    import gpl_pkg::*;

    logic                      valid_reg;
    color_t                    color_reg;
    color_t                    color_next;
    logic [NUM_CHAN-1:0][39:0] prod;

    always_comb
    begin
        color_next = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            // The reciprocal is exact for every dividend below 2**16.
            prod[ch] = 40'(blend.dividend[ch]) * 40'(blend.recip);
            color_next[ch * 8 +: 8] = prod[ch][RECIP_SHIFT +: 8];
        end
        if (blend.direct)
        begin
            color_next = blend.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.valid)
        begin
            color_reg <= color_next;
        end
    end

    assign valid = valid_reg;
    assign color = color_reg;

endmodule
